/* sv/e2d_pkg.sv */
// e2d_pkg: widths, division constants and calendar helpers for the
// epoch seconds to date converter. Used by every e2d module.
`timescale 1ns / 1ps

package e2d_pkg;

  localparam int SECS_W = 32;
  localparam int DAYS_W = 16;
  localparam int REM_W  = 17;
  localparam int OFF_W  = 8;
  localparam int DOY_W  = 9;
  localparam int YEAR_W = 12;

  // seconds / 86400 is done as (seconds >> 7) / 675
  localparam int          DAY_LOW_W  = 7;
  localparam int          DAY_HI_W   = SECS_W - DAY_LOW_W;
  localparam logic [25:0] DAY_RECIP  = 26'd50903316;
  localparam int          DAY_SHIFT  = 35;
  localparam logic [9:0]  DAY_DIV    = 10'd675;

  // seconds in day / 3600 is done as (rem >> 4) / 225
  localparam logic [12:0] HOUR_RECIP = 13'd4661;
  localparam int          HOUR_SHIFT = 20;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;

  // seconds in hour / 60 is done as (r >> 2) / 15
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  localparam int          MIN_SHIFT  = 14;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;

  // year guess, days / 365.25
  localparam logic [11:0] YEAR_RECIP = 12'd2871;
  localparam int          YEAR_SHIFT = 20;

  localparam logic [YEAR_W-1:0] BASE_YEAR    = 12'd1970;
  localparam logic [OFF_W-1:0]  CENTURY_SKIP = 8'd130;  // 2100, not a leap year
  localparam logic [DOY_W-1:0]  DAYS_COMMON  = 9'd365;
  localparam logic [2:0]        EPOCH_WDAY   = 3'd4;    // thursday

  // year offset from 1970 -> leap year
  function automatic logic is_leap(input logic [OFF_W-1:0] off);
    logic [OFF_W-1:0] y2;
    y2 = off + 8'd2;
    return (y2[1:0] == 2'b00) && (off != CENTURY_SKIP);
  endfunction

  // days before the first of a month, month index from 0
  function automatic logic [DOY_W-1:0] days_before(input logic leap,
                                                   input logic [3:0] idx);
    logic [DOY_W-1:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // modulo 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [17:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
       + 6'(v[14:12]) + 6'(v[17:15]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

/* sv/epoch_seconds_to_date.sv */
// epoch_seconds_to_date: top level, valid pipeline and stall control
// around the day split, date and clock units. Depends on e2d_pkg.
//
//   channel   direction  handshake                      payload
//   seconds   in         seconds_valid / seconds_stall  seconds_count
//   date      out        date_valid / date_stall        year .. weekday
//
// one item per cycle while date_stall does not hold a waiting output item;
// the path has nine register stages: three for the day split,
// six for the parallel date and clock units
// a stall on a waiting output item freezes every stage and seconds_stall
// reset clears the stage valid bits only, payload registers are not reset
`timescale 1ns / 1ps

module epoch_seconds_to_date
  import e2d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              seconds_valid,
  output logic              seconds_stall,
  input  logic [SECS_W-1:0] seconds_count,
  output logic              date_valid,
  input  logic              date_stall,
  output logic [YEAR_W-1:0] year,
  output logic [3:0]        month,
  output logic [4:0]        day_of_month,
  output logic [4:0]        hour,
  output logic [5:0]        minute,
  output logic [5:0]        sec,
  output logic [2:0]        weekday
);

  localparam int STAGES = 9;

  logic [STAGES-1:0] vld;
  logic              en;
  logic [DAYS_W-1:0] days;
  logic [REM_W-1:0]  day_secs;

  assign seconds_stall = vld[STAGES-1] & date_stall;
  assign en            = ~seconds_stall;
  assign date_valid    = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], seconds_valid};
    end
  end

  e2d_day_split u_split (
    .clk           (clk),
    .en            (en),
    .seconds_count (seconds_count),
    .days          (days),
    .day_secs      (day_secs)
  );

  e2d_date u_date (
    .clk          (clk),
    .en           (en),
    .days         (days),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday)
  );

  e2d_clock u_clock (
    .clk      (clk),
    .en       (en),
    .day_secs (day_secs),
    .hour     (hour),
    .minute   (minute),
    .sec      (sec)
  );

endmodule

/* sv/e2d_day_split.sv */
// e2d_day_split: three stage split of the seconds count into whole days
// and seconds within the day. Depends on e2d_pkg.
`timescale 1ns / 1ps

module e2d_day_split
  import e2d_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SECS_W-1:0] seconds_count,
  output logic [DAYS_W-1:0] days,
  output logic [REM_W-1:0]  day_secs
);

  logic [DAY_HI_W-1:0]  s1_hi;
  logic [DAY_LOW_W-1:0] s1_lo;
  logic [50:0]          s1_prod;

  logic [DAY_HI_W-1:0]  s2_hi;
  logic [DAY_LOW_W-1:0] s2_lo;
  logic [DAYS_W-1:0]    s2_quot;
  logic [25:0]          s2_prod;

  logic [DAYS_W-1:0]    quot_next;
  logic [DAY_HI_W-1:0]  diff;
  logic [10:0]          frac;
  logic [DAYS_W-1:0]    days_next;
  logic [9:0]           frac_next;

  assign quot_next = s1_prod[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];

  // estimate is exact or one low
  always_comb begin
    diff = s2_hi - s2_prod[DAY_HI_W-1:0];
    frac = diff[10:0];
    if (frac >= 11'(DAY_DIV)) begin
      days_next = s2_quot + 16'd1;
      frac_next = 10'(frac - 11'(DAY_DIV));
    end else begin
      days_next = s2_quot;
      frac_next = frac[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hi    <= seconds_count[SECS_W-1:DAY_LOW_W];
      s1_lo    <= seconds_count[DAY_LOW_W-1:0];
      s1_prod  <= 51'(seconds_count[SECS_W-1:DAY_LOW_W]) * 51'(DAY_RECIP);
      s2_hi    <= s1_hi;
      s2_lo    <= s1_lo;
      s2_quot  <= quot_next;
      s2_prod  <= 26'(quot_next) * 26'(DAY_DIV);
      days     <= days_next;
      day_secs <= {frac_next, s2_lo};
    end
  end

endmodule

/* sv/e2d_date.sv */
// e2d_date: six stage conversion of a day count into year, month, day of
// month and weekday, with a guess-and-correct year step. Depends on e2d_pkg.
`timescale 1ns / 1ps

module e2d_date
  import e2d_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DAYS_W-1:0] days,
  output logic [YEAR_W-1:0] year,
  output logic [3:0]        month,
  output logic [4:0]        day_of_month,
  output logic [2:0]        weekday
);

  logic [DAYS_W-1:0] d1_days;
  logic [27:0]       d1_prod;
  logic [2:0]        d1_wday;

  logic [DAYS_W-1:0] d2_days;
  logic [OFF_W-1:0]  d2_guess;
  logic [DAYS_W-1:0] d2_start;
  logic [2:0]        d2_wday;

  logic [YEAR_W-1:0] d3_year;
  logic [OFF_W-1:0]  d3_off;
  logic [DOY_W-1:0]  d3_doy;
  logic [2:0]        d3_wday;

  logic [YEAR_W-1:0] d4_year;
  logic [3:0]        d4_month;
  logic [4:0]        d4_dom;
  logic [2:0]        d4_wday;

  logic [YEAR_W-1:0] d5_year;
  logic [3:0]        d5_month;
  logic [4:0]        d5_dom;
  logic [2:0]        d5_wday;

  logic [OFF_W-1:0]  guess;
  logic [DAYS_W-1:0] start_next;
  logic [16:0]       delta;
  logic [DOY_W-1:0]  len_cur;
  logic [DOY_W-1:0]  len_prev;
  logic [9:0]        over;
  logic [OFF_W-1:0]  off_next;
  logic [DOY_W-1:0]  doy_next;
  logic              leap;
  logic [3:0]        midx;
  logic [DOY_W-1:0]  dom_off;

  // first day of the guessed year, counted from 1970
  always_comb begin
    guess      = d1_prod[YEAR_SHIFT+OFF_W-1:YEAR_SHIFT];
    start_next = 16'(guess) * 16'(DAYS_COMMON) + 16'((guess + 8'd1) >> 2);
    if (guess > CENTURY_SKIP) begin
      start_next = start_next - 16'd1;
    end
  end

  // correct the guess by one year either way
  always_comb begin
    delta    = {1'b0, d2_days} - {1'b0, d2_start};
    len_cur  = DAYS_COMMON + 9'(is_leap(d2_guess));
    len_prev = DAYS_COMMON + 9'(is_leap(d2_guess - 8'd1));
    over     = delta[9:0] - 10'(len_cur);
    if (delta[16]) begin
      off_next = d2_guess - 8'd1;
      doy_next = delta[8:0] + len_prev;
    end else if (delta[9:0] >= 10'(len_cur)) begin
      off_next = d2_guess + 8'd1;
      doy_next = over[8:0];
    end else begin
      off_next = d2_guess;
      doy_next = delta[8:0];
    end
  end

  // month from cumulative month days
  always_comb begin
    leap = is_leap(d3_off);
    midx = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (d3_doy >= days_before(leap, 4'(m))) begin
        midx = 4'(m);
      end
    end
    dom_off = d3_doy - days_before(leap, midx) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_days      <= days;
      d1_prod      <= 28'(days) * 28'(YEAR_RECIP);
      d1_wday      <= mod7(18'(days) + 18'(EPOCH_WDAY));
      d2_days      <= d1_days;
      d2_guess     <= guess;
      d2_start     <= start_next;
      d2_wday      <= d1_wday;
      d3_year      <= BASE_YEAR + 12'(off_next);
      d3_off       <= off_next;
      d3_doy       <= doy_next;
      d3_wday      <= d2_wday;
      d4_year      <= d3_year;
      d4_month     <= midx + 4'd1;
      d4_dom       <= dom_off[4:0];
      d4_wday      <= d3_wday;
      d5_year      <= d4_year;
      d5_month     <= d4_month;
      d5_dom       <= d4_dom;
      d5_wday      <= d4_wday;
      year         <= d5_year;
      month        <= d5_month;
      day_of_month <= d5_dom;
      weekday      <= d5_wday;
    end
  end

endmodule

/* sv/e2d_clock.sv */
// e2d_clock: six stage split of the seconds within a day into hour,
// minute and second by reciprocal multiplies. Depends on e2d_pkg.
`timescale 1ns / 1ps

module e2d_clock
  import e2d_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [REM_W-1:0] day_secs,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       sec
);

  logic [REM_W-1:0] t1_secs;
  logic [25:0]      t1_prod;

  logic [REM_W-1:0] t2_secs;
  logic [4:0]       t2_hour;
  logic [REM_W-1:0] t2_hsecs;

  logic [4:0]       t3_hour;
  logic [11:0]      t3_rem;

  logic [4:0]       t4_hour;
  logic [11:0]      t4_rem;
  logic [20:0]      t4_prod;

  logic [4:0]       t5_hour;
  logic [11:0]      t5_rem;
  logic [5:0]       t5_min;
  logic [11:0]      t5_msecs;

  logic [4:0]       hour_next;
  logic [REM_W-1:0] hour_rem;
  logic [5:0]       min_next;
  logic [11:0]      sec_rem;

  assign hour_next = t1_prod[HOUR_SHIFT+4:HOUR_SHIFT];
  assign hour_rem  = t2_secs - t2_hsecs;
  assign min_next  = t4_prod[MIN_SHIFT+5:MIN_SHIFT];
  assign sec_rem   = t5_rem - t5_msecs;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_secs  <= day_secs;
      t1_prod  <= 26'(day_secs[REM_W-1:4]) * 26'(HOUR_RECIP);
      t2_secs  <= t1_secs;
      t2_hour  <= hour_next;
      t2_hsecs <= 17'(hour_next) * 17'(SEC_PER_HOUR);
      t3_hour  <= t2_hour;
      t3_rem   <= hour_rem[11:0];
      t4_hour  <= t3_hour;
      t4_rem   <= t3_rem;
      t4_prod  <= 21'(t3_rem[11:2]) * 21'(MIN_RECIP);
      t5_hour  <= t4_hour;
      t5_rem   <= t4_rem;
      t5_min   <= min_next;
      t5_msecs <= 12'(min_next) * 12'(SEC_PER_MIN);
      hour     <= t5_hour;
      minute   <= t5_min;
      sec      <= sec_rem[5:0];
    end
  end

endmodule
